// File: hw/rtl/pps_pkg.sv
// Package for the preemptive priority scheduler: sizes, opcodes, state codes
// and the command and status structs between controller and datapath.
// No dependencies.
package pps_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int TIME_BITS     = 16;
   localparam int SLOT_BITS     = $clog2(MAX_PROCESSES);
   localparam int COUNT_BITS    = 5;
   localparam int PRI_BITS      = 8;
   localparam int SUM_BITS      = 20;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_DRAIN = 7'b0000100,
      ST_FETCH = 7'b0001000,
      ST_CALC  = 7'b0010000,
      ST_WCALC = 7'b0100000,
      ST_ACCUM = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic tick_start;
      logic scan_issue;
      logic fetch;
      logic calc;
      logic wcalc;
      logic accum;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic issue_last;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/pps_ctrl.sv
// Controller state machine of the preemptive priority scheduler.
// Depends on pps_pkg; drives pps_datapath through cmd_type, reads sts_type.
module pps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_stall,
   input  pps_pkg::sts_type sts,
   output pps_pkg::cmd_type cmd
);
   import pps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
                  state_in = sts.n_zero ? ST_FETCH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_WCALC;
         end
         ST_WCALC: begin
            cmd.wcalc = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (sts.out_free) begin
               cmd.accum = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_accum_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCUM && !sts.out_free) |=> state_ff == ST_ACCUM)
      else $error("result dropped while output busy");

   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_opcode == OP_TICK)
      |=> (state_ff == ST_SCAN || state_ff == ST_FETCH))
      else $error("tick transaction did not start a scan");

endmodule

// File: hw/rtl/pps_datapath.sv
// Datapath of the preemptive priority scheduler: slot stores, priority scan,
// slot update, running totals and the result register.
// Depends on pps_pkg; commanded by pps_ctrl.
module pps_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pps_pkg::SLOT_BITS-1:0]      req_slot,
   input  logic [pps_pkg::TIME_BITS-1:0]      req_arrival_time,
   input  logic [pps_pkg::TIME_BITS-1:0]      req_burst_length,
   input  logic [pps_pkg::PRI_BITS-1:0]       req_priority_level,
   input  logic                               csr_valid,
   input  logic [pps_pkg::COUNT_BITS-1:0]     csr_data,
   input  pps_pkg::cmd_type                   cmd,
   output pps_pkg::sts_type                   sts,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pps_pkg::SLOT_BITS-1:0]      rsp_chosen_slot,
   output logic                               rsp_idle,
   output logic [pps_pkg::TIME_BITS-1:0]      rsp_tick_end,
   output logic                               rsp_finished,
   output logic [pps_pkg::TIME_BITS-1:0]      rsp_wait_time,
   output logic [pps_pkg::TIME_BITS-1:0]      rsp_turnaround,
   output logic                               rsp_all_done,
   output logic [pps_pkg::SUM_BITS-1:0]       rsp_wait_total,
   output logic [pps_pkg::SUM_BITS-1:0]       rsp_turnaround_total
);
   import pps_pkg::*;

   // slot stores
   logic [TIME_BITS-1:0] arrival_mem   [MAX_PROCESSES];
   logic [TIME_BITS-1:0] burst_mem     [MAX_PROCESSES];
   logic [TIME_BITS-1:0] remaining_mem [MAX_PROCESSES];
   logic [PRI_BITS-1:0]  priority_mem  [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] busy_ff;

   logic [SLOT_BITS-1:0] rd_addr;
   logic [TIME_BITS-1:0] arr_rd_ff, burst_rd_ff, rem_rd_ff;
   logic [PRI_BITS-1:0]  pri_rd_ff;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] used_n;
   logic [TIME_BITS-1:0]  time_ff;
   logic [SUM_BITS-1:0]   wait_sum_ff, tat_sum_ff;

   // scan pipeline
   logic [SLOT_BITS-1:0] idx_ff, idx_d_ff, best_ff;
   logic                 vld_d_ff, busy_d_ff, found_ff;
   logic [PRI_BITS-1:0]  best_pri_ff;
   logic                 take;

   // update
   logic [TIME_BITS-1:0] tick_end_ff, tat_ff, wt_ff, rem_new;
   logic                 fin_ff;
   logic [SUM_BITS:0]    wait_add, tat_add;
   logic                 live;

   logic                 rsp_valid_ff;
   logic [SLOT_BITS-1:0] chosen_ff;
   logic                 idle_ff, finished_ff, all_done_ff;
   logic [TIME_BITS-1:0] tick_out_ff, wait_out_ff, tat_out_ff;

   assign used_n = (count_ff > COUNT_BITS'(MAX_PROCESSES)) ?
                   COUNT_BITS'(MAX_PROCESSES) : count_ff;
   assign rd_addr = cmd.scan_issue ? idx_ff : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         arrival_mem[req_slot]  <= req_arrival_time;
         burst_mem[req_slot]    <= req_burst_length;
         priority_mem[req_slot] <= req_priority_level;
      end
      if (cmd.load) begin
         remaining_mem[req_slot] <= req_burst_length;
      end else if (cmd.calc && found_ff) begin
         remaining_mem[best_ff] <= rem_new;
      end
      arr_rd_ff   <= arrival_mem[rd_addr];
      burst_rd_ff <= burst_mem[rd_addr];
      rem_rd_ff   <= remaining_mem[rd_addr];
      pri_rd_ff   <= priority_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (cmd.load) begin
         busy_ff[req_slot] <= (req_burst_length != '0);
      end else if (cmd.calc && found_ff) begin
         busy_ff[best_ff] <= (rem_new != '0);
      end
   end

   // compare the slot whose data arrived this cycle
   assign take = vld_d_ff && busy_d_ff && (arr_rd_ff <= time_ff) &&
                 (!found_ff || (pri_rd_ff < best_pri_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         vld_d_ff <= cmd.scan_issue;
         if (cmd.tick_start) begin
            idx_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               idx_ff <= idx_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_d_ff  <= idx_ff;
      busy_d_ff <= busy_ff[idx_ff];
      if (cmd.tick_start) begin
         best_ff <= '0;
      end else if (take) begin
         best_ff     <= idx_d_ff;
         best_pri_ff <= pri_rd_ff;
      end
   end

   assign sts.n_zero     = (used_n == '0);
   assign sts.issue_last = ({1'b0, idx_ff} == COUNT_BITS'(used_n - 1'b1));
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rem_new = rem_rd_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         tick_end_ff <= (time_ff == TIME_MAX) ? time_ff : time_ff + 1'b1;
      end
      if (cmd.calc) begin
         fin_ff <= found_ff && (rem_new == '0);
         tat_ff <= (tick_end_ff >= arr_rd_ff) ? tick_end_ff - arr_rd_ff : '0;
      end
      if (cmd.wcalc) begin
         wt_ff <= (tat_ff >= burst_rd_ff) ? tat_ff - burst_rd_ff : '0;
      end
   end

   assign wait_add = {1'b0, wait_sum_ff} + (SUM_BITS+1)'(wt_ff);
   assign tat_add  = {1'b0, tat_sum_ff} + (SUM_BITS+1)'(tat_ff);

   always_comb begin
      live = 1'b0;
      for (int i = 0; i < MAX_PROCESSES; i++) begin
         if (busy_ff[i] && (COUNT_BITS'(i) < used_n)) begin
            live = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         wait_sum_ff <= '0;
         tat_sum_ff  <= '0;
      end else if (cmd.accum) begin
         time_ff <= tick_end_ff;
         if (fin_ff) begin
            wait_sum_ff <= wait_add[SUM_BITS] ? SUM_MAX : wait_add[SUM_BITS-1:0];
            tat_sum_ff  <= tat_add[SUM_BITS] ? SUM_MAX : tat_add[SUM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.accum) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accum) begin
         chosen_ff   <= found_ff ? best_ff : '0;
         idle_ff     <= !found_ff;
         tick_out_ff <= tick_end_ff;
         finished_ff <= fin_ff;
         wait_out_ff <= fin_ff ? wt_ff : '0;
         tat_out_ff  <= fin_ff ? tat_ff : '0;
         all_done_ff <= !live;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_chosen_slot      = chosen_ff;
   assign rsp_idle             = idle_ff;
   assign rsp_tick_end         = tick_out_ff;
   assign rsp_finished         = finished_ff;
   assign rsp_wait_time        = wait_out_ff;
   assign rsp_turnaround       = tat_out_ff;
   assign rsp_all_done         = all_done_ff;
   assign rsp_wait_total       = wait_sum_ff;
   assign rsp_turnaround_total = tat_sum_ff;

   a_fin_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && finished_ff) |-> !idle_ff)
      else $error("finished reported on an idle tick");

   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (wait_sum_ff >= $past(wait_sum_ff) && tat_sum_ff >= $past(tat_sum_ff)))
      else $error("running total decreased");

endmodule

// File: hw/rtl/preemptive_priority_scheduler_unit.sv
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
// A load transaction (opcode 0) writes one process slot with its arrival
// time, burst and priority and gives no result. A tick transaction
// (opcode 1) scans slots 0 .. n-1 one per cycle, n being process_count
// capped at 16, through the registered read port of the slot stores, picks
// the ready slot with the smallest priority number (lowest slot on ties),
// spends one tick of work on it and returns one result. A tick runs the
// scan steps, a step to drain the read pipeline, then the fetch, update,
// wait-time and totals steps; the scan and drain are skipped when no slot
// is in use. Time and the running totals saturate. The result register
// lets the next load be taken while a result is stalled; a further tick
// holds in its final step until the result register frees up. The
// process_count register may be written at any time the block is idle;
// csr_ready is always high.
module preemptive_priority_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [pps_pkg::SLOT_BITS-1:0]   req_slot,
   input  logic [pps_pkg::TIME_BITS-1:0]   req_arrival_time,
   input  logic [pps_pkg::TIME_BITS-1:0]   req_burst_length,
   input  logic [pps_pkg::PRI_BITS-1:0]    req_priority_level,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pps_pkg::SLOT_BITS-1:0]   rsp_chosen_slot,
   output logic                            rsp_idle,
   output logic [pps_pkg::TIME_BITS-1:0]   rsp_tick_end,
   output logic                            rsp_finished,
   output logic [pps_pkg::TIME_BITS-1:0]   rsp_wait_time,
   output logic [pps_pkg::TIME_BITS-1:0]   rsp_turnaround,
   output logic                            rsp_all_done,
   output logic [pps_pkg::SUM_BITS-1:0]    rsp_wait_total,
   output logic [pps_pkg::SUM_BITS-1:0]    rsp_turnaround_total,
   // configuration write channel: process_count
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pps_pkg::COUNT_BITS-1:0]  csr_data
);
   import pps_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // always take configuration writes
   assign csr_ready = 1'b1;

   pps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   pps_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_slot             (req_slot),
      .req_arrival_time     (req_arrival_time),
      .req_burst_length     (req_burst_length),
      .req_priority_level   (req_priority_level),
      .csr_valid            (csr_valid),
      .csr_data             (csr_data),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_chosen_slot      (rsp_chosen_slot),
      .rsp_idle             (rsp_idle),
      .rsp_tick_end         (rsp_tick_end),
      .rsp_finished         (rsp_finished),
      .rsp_wait_time        (rsp_wait_time),
      .rsp_turnaround       (rsp_turnaround),
      .rsp_all_done         (rsp_all_done),
      .rsp_wait_total       (rsp_wait_total),
      .rsp_turnaround_total (rsp_turnaround_total)
   );

endmodule
